// ===== sv/nta_pkg.sv =====
// nearest track association package: sizes, types and opcodes
// no dependencies
`default_nettype none
package nta_pkg;
	localparam int MaxTracks = 32;
	localparam int CoordBits = 12;
	localparam int DiagBits = 17;
	localparam int IdxBits = $clog2(MaxTracks);
	localparam int CntBits = $clog2(MaxTracks + 1);
	localparam int D2Bits = 2 * CoordBits + 1;
	localparam int QDepth = 2;

	typedef enum logic {
		OP_DETECT = 1'b0,
		OP_EOF = 1'b1
	} op_t;

	typedef struct packed {
		op_t op;
		logic [CoordBits-1:0] cx;
		logic [CoordBits-1:0] cy;
		logic [DiagBits-1:0] dg;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_TEST,
		ST_COMMIT
	} state_t;
endpackage
`default_nettype wire

// ===== sv/nta_front.sv =====
// front part: accepts input beats and queues them as items
// depends on nta_pkg
`default_nettype none
module nta_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic opcode,
	input wire logic [nta_pkg::CoordBits-1:0] center_x,
	input wire logic [nta_pkg::CoordBits-1:0] center_y,
	input wire logic [nta_pkg::DiagBits-1:0] diag_size,
	output logic q_valid,
	output nta_pkg::item_t q_item,
	input wire logic q_pop
);
	import nta_pkg::*;

	item_t buf_q [QDepth];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_stall = (cnt_q == 2'(QDepth));
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = buf_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= '{op: op_t'(opcode), cx: center_x, cy: center_y, dg: diag_size};
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule
`default_nettype wire

// ===== sv/nta_back.sv =====
// back part: nearest entry scan, match test and table update
// depends on nta_pkg
`default_nettype none
module nta_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	input wire nta_pkg::item_t q_item,
	output logic q_pop,
	output logic out_valid,
	input wire logic out_stall,
	output logic [nta_pkg::IdxBits-1:0] track_index,
	output logic is_new,
	output logic overflow,
	output logic [nta_pkg::CntBits-1:0] active_count
);
	import nta_pkg::*;

	logic [CoordBits-1:0] mem_x [MaxTracks];
	logic [CoordBits-1:0] mem_y [MaxTracks];
	logic [MaxTracks-1:0] trk_q, mat_q;
	logic [CntBits-1:0] ent_q;
	logic first_q;

	state_t st_q, st_d;
	item_t it_q;
	logic [CntBits-1:0] scan_q;
	logic [CoordBits-1:0] rx_s1, ry_s1;
	logic v_s1;
	logic [IdxBits-1:0] idx_s1;
	logic [D2Bits-1:0] best_q;
	logic [IdxBits-1:0] bidx_q;
	logic found_q;
	logic [2*DiagBits-1:0] dsq_q;

	logic [CoordBits-1:0] dx, dy;
	logic [D2Bits-1:0] d2;
	logic hit;
	logic can_load;
	logic out_free;

	assign out_free = !out_valid || !out_stall;
	assign can_load = (st_q == ST_IDLE) && q_valid && out_free;
	assign q_pop = can_load;

	// distance of the entry read last cycle
	assign dx = (it_q.cx >= rx_s1) ? it_q.cx - rx_s1 : rx_s1 - it_q.cx;
	assign dy = (it_q.cy >= ry_s1) ? it_q.cy - ry_s1 : ry_s1 - it_q.cy;
	assign d2 = D2Bits'(dx * dx) + D2Bits'(dy * dy);
	assign hit = found_q && ((2*DiagBits+2)'({best_q, 6'd0}) < (2*DiagBits+2)'(dsq_q));

	// sequencer next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (can_load) begin
				if (q_item.op == OP_EOF) st_d = ST_COMMIT;
				else st_d = ST_SCAN;
			end
			ST_SCAN: if (first_q || scan_q >= ent_q) st_d = ST_DRAIN;
			ST_DRAIN: st_d = ST_TEST;
			ST_TEST: st_d = ST_COMMIT;
			ST_COMMIT: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// coordinate memories, one read port each
	always_ff @(posedge clk) begin
		rx_s1 <= mem_x[scan_q[IdxBits-1:0]];
		ry_s1 <= mem_y[scan_q[IdxBits-1:0]];
		if (st_q == ST_COMMIT && it_q.op == OP_DETECT && (hit || ent_q < CntBits'(MaxTracks)))
		begin
			mem_x[hit ? bidx_q : ent_q[IdxBits-1:0]] <= it_q.cx;
			mem_y[hit ? bidx_q : ent_q[IdxBits-1:0]] <= it_q.cy;
		end
	end

	// item register and diagonal square
	always_ff @(posedge clk) begin
		if (can_load) it_q <= q_item;
		if (st_q == ST_SCAN) dsq_q <= it_q.dg * it_q.dg;
		idx_s1 <= scan_q[IdxBits-1:0];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			trk_q <= '0;
			mat_q <= '0;
			ent_q <= '0;
			first_q <= 1'b1;
			scan_q <= '0;
			v_s1 <= 1'b0;
			found_q <= 1'b0;
			best_q <= '0;
			bidx_q <= '0;
			out_valid <= 1'b0;
			track_index <= '0;
			is_new <= 1'b0;
			overflow <= 1'b0;
			active_count <= '0;
		end else begin
			st_q <= st_d;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (can_load) begin
				scan_q <= '0;
				found_q <= 1'b0;
			end
			// one entry read per cycle; compare in the following cycle
			v_s1 <= (st_q == ST_SCAN) && !first_q && scan_q < ent_q
				&& trk_q[scan_q[IdxBits-1:0]];
			if (st_q == ST_SCAN && scan_q < ent_q) scan_q <= scan_q + 1'b1;
			if (v_s1 && (!found_q || d2 < best_q)) begin
				found_q <= 1'b1;
				best_q <= d2;
				bidx_q <= idx_s1;
			end
			// table update and result
			if (st_q == ST_COMMIT) begin
				out_valid <= 1'b1;
				is_new <= 1'b0;
				overflow <= 1'b0;
				track_index <= '0;
				if (it_q.op == OP_EOF) begin
					trk_q <= trk_q & mat_q;
					mat_q <= '0;
					first_q <= 1'b0;
					active_count <= CntBits'($countones(trk_q & mat_q));
				end else if (hit) begin
					trk_q[bidx_q] <= 1'b1;
					mat_q[bidx_q] <= 1'b1;
					track_index <= bidx_q;
					active_count <= CntBits'($countones(trk_q | (MaxTracks'(1) << bidx_q)));
				end else if (ent_q < CntBits'(MaxTracks)) begin
					trk_q[ent_q[IdxBits-1:0]] <= 1'b1;
					mat_q[ent_q[IdxBits-1:0]] <= 1'b1;
					ent_q <= ent_q + 1'b1;
					track_index <= ent_q[IdxBits-1:0];
					is_new <= 1'b1;
					active_count <= CntBits'($countones(trk_q
						| (MaxTracks'(1) << ent_q[IdxBits-1:0])));
				end else begin
					overflow <= 1'b1;
					active_count <= CntBits'($countones(trk_q));
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/nearest_track_association.sv =====
// top level of nearest track association
// depends on nta_pkg, nta_front, nta_back
`default_nettype none
// Keeps a table of up to 32 tracks and matches each detection beat to the
// nearest tracked entry by squared distance, appending a new entry while the
// table has room when no entry lies within one eighth of the detection's
// diagonal. One result beat comes out per input beat. A detection reads the
// table one entry per cycle from the coordinate memory through a single
// distance unit; an end-of-frame beat skips the search.
// A two-entry queue in front lets input beats arrive while an item is being
// searched. The result register holds a finished result under stall, and the
// next item is loaded no earlier than the cycle in which that result is taken.
module nearest_track_association (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic opcode,
	input wire logic [nta_pkg::CoordBits-1:0] center_x,
	input wire logic [nta_pkg::CoordBits-1:0] center_y,
	input wire logic [nta_pkg::DiagBits-1:0] diag_size,
	output logic out_valid,
	input wire logic out_stall,
	output logic [nta_pkg::IdxBits-1:0] track_index,
	output logic is_new,
	output logic overflow,
	output logic [nta_pkg::CntBits-1:0] active_count
);
	import nta_pkg::*;

	logic q_valid, q_pop;
	item_t q_item;

	// input queue
	nta_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .center_x(center_x), .center_y(center_y),
		.diag_size(diag_size), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	// search and update
	nta_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.out_valid(out_valid), .out_stall(out_stall), .track_index(track_index),
		.is_new(is_new), .overflow(overflow), .active_count(active_count)
	);

	// checks
	a_new_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_new && overflow)) else $error("new and overflow together");
	a_ovf_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflow) |-> (track_index == '0)) else $error("overflow index");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (active_count <= CntBits'(MaxTracks))) else $error("count range");
endmodule
`default_nettype wire

// ===== test/nearest_track_association_tb.sv =====
// testbench for nearest_track_association: checks each result beat against
// a predictor of the track table kept here; depends on nta_pkg and the rtl
`timescale 1ns / 1ps
`default_nettype none
module nearest_track_association_tb;
	import nta_pkg::*;

	localparam int WatchLimit = 20000;
	localparam int NumRandom = 1800;

	typedef struct {
		logic [IdxBits-1:0] idx;
		logic nw;
		logic ovf;
		logic [CntBits-1:0] cnt;
	} assoc_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic opcode;
	logic [CoordBits-1:0] center_x;
	logic [CoordBits-1:0] center_y;
	logic [DiagBits-1:0] diag_size;
	logic out_valid;
	logic out_stall;
	logic [IdxBits-1:0] track_index;
	logic is_new;
	logic overflow;
	logic [CntBits-1:0] active_count;

	item_t pending_beats[$];
	assoc_t expected_assoc[$];
	int errors;
	int send_idle_pct;
	int recv_idle_pct;
	bit stim_done;
	int watch_cnt;

	// predictor copy of the track table
	logic [CoordBits-1:0] tk_x[MaxTracks];
	logic [CoordBits-1:0] tk_y[MaxTracks];
	logic [DiagBits-1:0] tk_dg[MaxTracks];
	bit tk_on[MaxTracks];
	bit tk_hit[MaxTracks];
	int tk_used;
	bit in_first;

	nearest_track_association dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .center_x(center_x), .center_y(center_y),
		.diag_size(diag_size), .out_valid(out_valid), .out_stall(out_stall),
		.track_index(track_index), .is_new(is_new), .overflow(overflow),
		.active_count(active_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// table update for one accepted beat
	function automatic assoc_t associate(item_t it);
		assoc_t r;
		bit found;
		bit hit;
		int best;
		longint unsigned d2, best_d2, dx, dy;
		r.idx = '0;
		r.nw = 1'b0;
		r.ovf = 1'b0;
		if (it.op == OP_EOF) begin
			for (int i = 0; i < MaxTracks; i++) begin
				if (!tk_hit[i]) tk_on[i] = 1'b0;
				tk_hit[i] = 1'b0;
			end
			in_first = 1'b0;
		end else begin
			found = 1'b0;
			hit = 1'b0;
			best = 0;
			best_d2 = 0;
			if (!in_first) begin
				for (int i = 0; i < tk_used; i++) begin
					if (tk_on[i]) begin
						dx = (it.cx >= tk_x[i]) ? it.cx - tk_x[i] : tk_x[i] - it.cx;
						dy = (it.cy >= tk_y[i]) ? it.cy - tk_y[i] : tk_y[i] - it.cy;
						d2 = dx * dx + dy * dy;
						if (!found || d2 < best_d2) begin
							found = 1'b1;
							best_d2 = d2;
							best = i;
						end
					end
				end
				hit = found && (64 * best_d2 < longint'(it.dg) * longint'(it.dg));
			end
			if (!hit && tk_used < MaxTracks) begin
				best = tk_used;
				tk_used++;
				r.nw = 1'b1;
			end
			if (hit || r.nw) begin
				tk_x[best] = it.cx;
				tk_y[best] = it.cy;
				tk_dg[best] = it.dg;
				tk_on[best] = 1'b1;
				tk_hit[best] = 1'b1;
				r.idx = best[IdxBits-1:0];
			end else begin
				r.ovf = 1'b1;
			end
		end
		r.cnt = '0;
		for (int i = 0; i < MaxTracks; i++) r.cnt += tk_on[i];
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// append one beat to the pending queue
	task automatic enqueue_beat(item_t it);
		pending_beats.insert(pending_beats.size(), it);
	endtask

	function automatic item_t det(int x, int y, int d);
		item_t it;
		it.op = OP_DETECT;
		it.cx = x[CoordBits-1:0];
		it.cy = y[CoordBits-1:0];
		it.dg = d[DiagBits-1:0];
		return it;
	endfunction

	function automatic item_t eof_beat();
		item_t it;
		it = det($urandom, $urandom, $urandom);
		it.op = OP_EOF;
		return it;
	endfunction

	// random frame: detections near remembered tracks with random noise, or at new random positions
	task automatic queue_frame(int n, int near_pct);
		int px[$];
		int py[$];
		int k, x, y;
		for (int i = 0; i < n; i++) begin
			if (px.size() > 0 && $urandom_range(99) < near_pct) begin
				k = $urandom_range(px.size() - 1);
				x = px[k] + $urandom_range(40) - 20;
				y = py[k] + $urandom_range(40) - 20;
				if ($urandom_range(9) == 0) begin
					x = $urandom_range(4095);
					y = $urandom_range(4095);
				end
				enqueue_beat(det(x, y, $urandom_range(9) == 0
					? $urandom_range(131071) : $urandom_range(1600)));
			end else begin
				x = $urandom_range(4095);
				y = $urandom_range(4095);
				px.insert(px.size(), x);
				py.insert(py.size(), y);
				enqueue_beat(det(x, y, $urandom_range(131071)));
			end
		end
		enqueue_beat(eof_beat());
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
			if (!in_valid || !in_stall) begin
				if (in_valid) void'(pending_beats.pop_front());
				if (pending_beats.size() > 0 && pending_beats[0].op === 1'bx) begin
					// pause marker: hold until every result is back
					if (expected_assoc.size() == 0 && !(in_valid && !in_stall))
						void'(pending_beats.pop_front());
					in_valid <= 1'b0;
				end else if (pending_beats.size() > 0
						&& $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					opcode <= pending_beats[0].op;
					center_x <= pending_beats[0].cx;
					center_y <= pending_beats[0].cy;
					diag_size <= pending_beats[0].dg;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: predicts on input acceptance, checks on output acceptance
	always @(posedge clk) begin
		assoc_t w;
		item_t it;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				it.op = op_t'(opcode);
				it.cx = center_x;
				it.cy = center_y;
				it.dg = diag_size;
				expected_assoc.insert(expected_assoc.size(), associate(it));
			end
			if (out_valid && !out_stall) begin
				if (expected_assoc.size() == 0) begin
					report_mismatch("unexpected beat", track_index, 0);
				end else begin
					w = expected_assoc.pop_front();
					if (track_index !== w.idx) report_mismatch("track_index", track_index, w.idx);
					if (is_new !== w.nw) report_mismatch("is_new", is_new, w.nw);
					if (overflow !== w.ovf) report_mismatch("overflow", overflow, w.ovf);
					if (active_count !== w.cnt)
						report_mismatch("active_count", active_count, w.cnt);
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) watch_cnt <= 0;
			else watch_cnt <= watch_cnt + 1;
		end
	end

	initial begin
		item_t pause;
		int total;
		errors = 0;
		watch_cnt = 0;
		stim_done = 1'b0;
		send_idle_pct = 27;
		recv_idle_pct = 81;
		in_valid = 1'b0;
		out_stall = 1'b0;
		opcode = 1'b0;
		center_x = '0;
		center_y = '0;
		diag_size = '0;
		in_first = 1'b1;
		tk_used = 0;
		for (int i = 0; i < MaxTracks; i++) begin
			tk_on[i] = 1'b0;
			tk_hit[i] = 1'b0;
		end
		pause = det(0, 0, 0);
		pause.op = op_t'(1'bx);

		// directed: first frame, extremes, ties, zero diagonal, no tracked entry
		enqueue_beat(det(0, 0, 0));
		enqueue_beat(det(4095, 4095, 131071));
		enqueue_beat(det(100, 100, 16));
		enqueue_beat(det(104, 100, 16));
		enqueue_beat(eof_beat());
		enqueue_beat(det(102, 100, 131071));
		enqueue_beat(det(102, 100, 131071));
		enqueue_beat(det(4095, 4095, 0));
		enqueue_beat(det(2048, 2048, 65536));
		enqueue_beat(pause);
		enqueue_beat(eof_beat());
		enqueue_beat(eof_beat());
		enqueue_beat(eof_beat());
		enqueue_beat(det(1, 1, 1));
		enqueue_beat(det(2730, 1365, 86381));
		// far-apart tiny tracks, each appending a new table entry
		for (int i = 0; i < 8; i++)
			enqueue_beat(det(i * 500, 4095 - i * 500, 1));
		enqueue_beat(eof_beat());

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		total = 0;
		for (int ph = 0; ph < 3; ph++) begin
			while (total < (ph + 1) * NumRandom / 3) begin
				int n;
				n = $urandom_range(8) + ($urandom_range(5) == 0 ? 20 : 0);
				queue_frame(n, 80);
				total += n + 1;
				if ($urandom_range(30) == 0) enqueue_beat(pause);
			end
			enqueue_beat(pause);
			while (pending_beats.size() > 0 || in_valid) begin
				@(posedge clk);
				if (watch_cnt >= WatchLimit) begin
					$display("nearest_track_association verification failed");
					$finish;
				end
			end
			if (ph == 0) begin
				send_idle_pct = 81;
				recv_idle_pct = 27;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		end
		while (expected_assoc.size() > 0) begin
			@(posedge clk);
			if (watch_cnt >= WatchLimit) begin
				$display("nearest_track_association verification failed");
				$finish;
			end
		end
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_assoc.size() == 0) begin
			$display("nearest_track_association verification clean");
		end else begin
			$display("nearest_track_association verification failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
